// ===== design/bsti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsti_pkg
// Shared types and constants for the binary search tree index: node layout,
// status codes and input order modes.
// ----------------------------------------------------------------------------
package bsti_pkg;

   // node table size and derived widths
   localparam int NODES   = 1024;
   localparam int NODE_AW = $clog2(NODES);
   localparam int LINK_W  = $clog2(NODES + 1);
   localparam int KEY_W   = 32;
   localparam int REC_W   = 20;

   // link value meaning no child (all ones, never below the node count)
   localparam logic [LINK_W-1:0] NO_CHILD = {LINK_W{1'b1}};
   localparam logic [LINK_W-1:0] NODES_L  = LINK_W'(NODES);

   // input order modes
   localparam logic [1:0] ORDER_TREE = 2'd0;
   localparam logic [1:0] ORDER_ASC  = 2'd1;
   localparam logic [1:0] ORDER_DESC = 2'd2;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_FOUND     = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   // one entry of the node table
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [REC_W-1:0]        record;
      logic [LINK_W-1:0]       left;
      logic [LINK_W-1:0]       right;
   } node_type;

   // result handed from the walker to the output register
   typedef struct packed {
      status_type       status;
      logic [REC_W-1:0] position;
   } result_type;

endpackage

// ===== design/bsti_node_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsti_node_ram
// Node table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsti_node_ram
   import bsti_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [NODE_AW-1:0] wr_addr,
   input  node_type           wr_data,
   input  logic               rd_en,
   input  logic [NODE_AW-1:0] rd_addr,
   output node_type           rd_data
);

   node_type mem [NODES];
   node_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bsti_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsti_walker
// Sequencer for one transaction: walks the node table one node per cycle,
// hangs a new node under the leaf reached, appends chain nodes, and holds
// the result until the output register takes it.
// ----------------------------------------------------------------------------
module bsti_walker
   import bsti_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              input_order,
   // request side
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic [REC_W-1:0]        req_record,
   input  logic                    req_last,
   // result side
   output logic                    res_valid,
   input  logic                    res_take,
   output result_type              res_data,
   // node table
   output logic                    wr_en,
   output logic [NODE_AW-1:0]      wr_addr,
   output node_type                wr_data,
   output logic                    rd_en,
   output logic [NODE_AW-1:0]      rd_addr,
   input  node_type                rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CMP    = 4'b0010,
      ST_APPEND = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [LINK_W-1:0]       count_ff, count_in;
   logic [NODE_AW-1:0]      cur_ff, cur_in;
   logic                    op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [REC_W-1:0]        rec_ff, rec_in;
   logic [LINK_W-1:0]       new_left_ff, new_left_in;
   logic [LINK_W-1:0]       new_right_ff, new_right_in;
   status_type              status_ff, status_in;
   logic [REC_W-1:0]        pos_ff, pos_in;

   logic                    accept;
   logic                    chain_mode;
   logic                    key_eq;
   logic                    key_lt;
   logic [LINK_W-1:0]       next_link;
   logic                    next_ok;
   logic [LINK_W-1:0]       chain_link;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign chain_mode = (input_order == ORDER_ASC) || (input_order == ORDER_DESC);
   assign chain_link = req_last ? NO_CHILD : (count_ff + LINK_W'(1));

   // compare against the node just read
   assign key_eq    = (key_ff == rd_data.key);
   assign key_lt    = (key_ff < rd_data.key);
   assign next_link = key_lt ? rd_data.left : rd_data.right;
   assign next_ok   = (next_link < count_ff);

   assign res_valid         = (state_ff == ST_DONE);
   assign res_data.status   = status_ff;
   assign res_data.position = pos_ff;

   // next state and memory control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      rec_in       = rec_ff;
      new_left_in  = new_left_ff;
      new_right_in = new_right_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in        = req_op;
               key_in       = req_key;
               rec_in       = req_record;
               pos_in       = '0;
               cur_in       = '0;
               new_left_in  = NO_CHILD;
               new_right_in = NO_CHILD;
               if (req_op == OP_SEARCH) begin
                  if (count_ff == '0) begin
                     status_in = STATUS_NOT_FOUND;
                     state_in  = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = ST_CMP;
                  end
               end else if (count_ff >= NODES_L) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_DONE;
               end else if (chain_mode) begin
                  if (input_order == ORDER_ASC) begin
                     new_right_in = chain_link;
                  end else begin
                     new_left_in = chain_link;
                  end
                  state_in = ST_APPEND;
               end else if (count_ff == '0) begin
                  state_in = ST_APPEND;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_CMP;
               end
            end
         end

         ST_CMP: begin
            if (key_eq) begin
               if (op_ff == OP_SEARCH) begin
                  status_in = STATUS_FOUND;
                  pos_in    = rd_data.record;
               end else begin
                  status_in = STATUS_DUPLICATE;
               end
               state_in = ST_DONE;
            end else if (next_ok) begin
               // descend one level
               rd_en    = 1'b1;
               rd_addr  = next_link[NODE_AW-1:0];
               cur_in   = next_link[NODE_AW-1:0];
            end else if (op_ff == OP_SEARCH) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_DONE;
            end else begin
               // hang the new node under this leaf
               wr_en = 1'b1;
               if (key_lt) begin
                  wr_data.left = count_ff;
               end else begin
                  wr_data.right = count_ff;
               end
               state_in = ST_APPEND;
            end
         end

         ST_APPEND: begin
            wr_en          = 1'b1;
            wr_addr        = count_ff[NODE_AW-1:0];
            wr_data.key    = key_ff;
            wr_data.record = rec_ff;
            wr_data.left   = new_left_ff;
            wr_data.right  = new_right_ff;
            count_in       = count_ff + LINK_W'(1);
            status_in      = STATUS_INSERTED;
            state_in       = ST_DONE;
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // transaction payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      op_ff        <= op_in;
      key_ff       <= key_in;
      rec_ff       <= rec_in;
      new_left_ff  <= new_left_in;
      new_right_ff <= new_right_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
   end

   // the table never holds more than its size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NODES_L)
      else $error("node count above table size");

   // a cycle never both reads and writes the node table
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("node table read and write in one cycle");

   // an append adds exactly one node
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPEND) |=> (count_ff == $past(count_ff) + LINK_W'(1)))
      else $error("append did not advance node count");

   // the node count moves only on an append
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_APPEND) |=> $stable(count_ff))
      else $error("node count changed outside append");

endmodule

// ===== design/binary_search_tree_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_search_tree_index
// Binary search tree index over a node table with insert and search
// transactions, a chain insert mode and a registered result stream.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. The node table has a single read
// port with registered read data, so a walk visits one node per cycle. A
// tree insert writes the leaf link and the new node in separate cycles, in
// the compare and the append state. A chain insert, a first insert, a
// full-table insert or an empty-table search needs no walk. A result
// sits in the output register while the next request is accepted. The
// node table needs no clearing after reset: only entries below the node
// count are ever read.
module binary_search_tree_index
   import bsti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // key [31:0], record_position [51:32], zero pad
   input  logic [0:0]  req_tuser,   // op
   input  logic        req_tlast,   // last_item
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found_position [19:0], zero pad
   output logic [2:0]  rsp_tuser,   // status
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data     // input_order
);

   logic [1:0] order_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   logic       res_valid;
   logic       res_take;
   result_type res_data;
   logic       wr_en;
   logic [NODE_AW-1:0] wr_addr;
   node_type   wr_data;
   logic       rd_en;
   logic [NODE_AW-1:0] rd_addr;
   node_type   rd_data;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_TREE;
      end else if (csr_valid && csr_ready) begin
         order_ff <= csr_data;
      end
   end

   bsti_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .input_order (order_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser[0]),
      .req_key     (req_tdata[31:0]),
      .req_record  (req_tdata[51:32]),
      .req_last    (req_tlast),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res_data    (res_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   bsti_node_ram u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register, loaded when empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.position};

endmodule

// ===== dv/binary_search_tree_index_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_search_tree_index_tb
// Self-checking bench for the tree index. A directed table covers the empty
// table, chain runs in both directions, the spare order mode, key and record
// extremes and refused duplicates. Random phases follow: tree inserts, chain
// runs (well formed and broken) and searches under every input order, then
// the node table is filled to the brim and full-table inserts are checked.
// Every response is compared with the directed table or a behavioural copy of the index.
// ----------------------------------------------------------------------------
module binary_search_tree_index_tb;
   import bsti_pkg::*;

   localparam logic [1:0]              ORDER_SPARE = 2'd3;
   localparam logic signed [KEY_W-1:0] KEY_LOW     = 32'h8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_HIGH    = 32'h7FFF_FFFF;
   localparam int                      PHASE_ITEMS = 140;

   // one line of the directed table: an order write or a request
   typedef struct packed {
      logic                    is_cfg;
      logic [1:0]              order;
      logic                    op;
      logic signed [KEY_W-1:0] key;
      logic [REC_W-1:0]        rec;
      logic                    last;
      logic                    typed;
      result_type              want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;    // key [31:0], record_position [51:32], zero pad
   logic [0:0]  req_tuser  = '0;    // op
   logic        req_tlast  = 1'b0;  // last_item
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // found_position [19:0], zero pad
   logic [2:0]  rsp_tuser;          // status
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data   = '0;    // input_order

   // copy of the index used for prediction
   logic signed [KEY_W-1:0] idx_key    [NODES];
   logic [REC_W-1:0]        idx_record [NODES];
   int                      idx_left   [NODES];
   int                      idx_right  [NODES];
   int                      idx_count  = 0;
   logic [1:0]              idx_order  = ORDER_TREE;

   logic signed [KEY_W-1:0] stored_keys[$];
   result_type              awaited_results[$];
   stim_row_type            directed_rows[$];
   int                      mismatch_count = 0;
   int                      burst_left     = 0;
   logic [9:0]              stall_tick     = '0;

   binary_search_tree_index i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // overall time limit
   initial begin
      #80_000_000;
      $display("Mismatches found");
      $finish;
   end

   // response back-pressure: always ready, coin flips, one in four, mostly ready
   always @(posedge clock) begin
      stall_tick <= stall_tick + 10'd1;
      case (stall_tick[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom);
         2'd2: rsp_tready <= (stall_tick[1:0] == 2'd0);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   function automatic bit link_in_use(input int link);
      return link >= 0 && link < idx_count && link < NODES;
   endfunction

   // apply one request to the index copy and return its response
   function automatic result_type predict_index_op(input logic op,
         input logic signed [KEY_W-1:0] key, input logic [REC_W-1:0] rec,
         input logic last);
      result_type res;
      int         cur;
      int         nxt;
      int         steps;
      bit         done;
      int         new_left;
      int         new_right;
      res.status   = STATUS_NOT_FOUND;
      res.position = '0;
      new_left     = -1;
      new_right    = -1;
      cur          = 0;
      steps        = 0;
      done         = 0;
      if (op == OP_SEARCH) begin
         if (idx_count > 0) begin
            while (!done && steps < NODES) begin
               if (key == idx_key[cur]) begin
                  res.status   = STATUS_FOUND;
                  res.position = idx_record[cur];
                  done         = 1;
               end else begin
                  nxt = (key < idx_key[cur]) ? idx_left[cur] : idx_right[cur];
                  if (link_in_use(nxt)) cur = nxt;
                  else done = 1;
               end
               steps++;
            end
         end
         return res;
      end
      if (idx_count >= NODES) begin
         res.status = STATUS_FULL;
         return res;
      end
      res.status = STATUS_INSERTED;
      if (idx_order == ORDER_ASC || idx_order == ORDER_DESC) begin
         // chain insert: no walk, link to the next index unless marked last
         if (!last && idx_order == ORDER_ASC) new_right = idx_count + 1;
         if (!last && idx_order == ORDER_DESC) new_left = idx_count + 1;
      end else if (idx_count > 0) begin
         // tree insert: walk to a free link and hang the new node there
         while (!done && steps < NODES) begin
            if (key == idx_key[cur]) begin
               res.status = STATUS_DUPLICATE;
               done       = 1;
            end else if (key < idx_key[cur]) begin
               if (!link_in_use(idx_left[cur])) begin
                  idx_left[cur] = idx_count;
                  done          = 1;
               end else begin
                  cur = idx_left[cur];
               end
            end else begin
               if (!link_in_use(idx_right[cur])) begin
                  idx_right[cur] = idx_count;
                  done           = 1;
               end else begin
                  cur = idx_right[cur];
               end
            end
            steps++;
         end
      end
      if (res.status == STATUS_INSERTED) begin
         idx_key[idx_count]    = key;
         idx_record[idx_count] = rec;
         idx_left[idx_count]   = new_left;
         idx_right[idx_count]  = new_right;
         idx_count++;
      end
      return res;
   endfunction

   // mostly random keys, with repeats, extremes and a narrow band mixed in
   function automatic logic signed [KEY_W-1:0] pick_key();
      int unsigned             sel;
      logic signed [KEY_W-1:0] key;
      sel = $urandom_range(0, 99);
      key = KEY_W'($urandom);
      if (sel < 15 && stored_keys.size() > 0) begin
         key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (sel < 25) begin
         case ($urandom_range(0, 4))
            0: key = KEY_LOW;
            1: key = KEY_HIGH;
            2: key = 32'sd0;
            3: key = -32'sd1;
            default: key = 32'sd1;
         endcase
      end else if (sel < 40) begin
         key = KEY_W'(int'($urandom_range(0, 63)) - 32);
      end
      return key;
   endfunction

   function automatic logic signed [KEY_W-1:0] pick_search_key();
      if (stored_keys.size() > 0 && $urandom_range(0, 1) == 1)
         return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      return pick_key();
   endfunction

   function automatic void add_cfg(input logic [1:0] order);
      stim_row_type row;
      row        = '0;
      row.is_cfg = 1'b1;
      row.order  = order;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(input logic op, input logic signed [KEY_W-1:0] key,
         input logic [REC_W-1:0] rec, input logic last, input logic typed,
         input status_type status, input logic [REC_W-1:0] position);
      stim_row_type row;
      row               = '0;
      row.op            = op;
      row.key           = key;
      row.rec           = rec;
      row.last          = last;
      row.typed         = typed;
      row.want.status   = status;
      row.want.position = position;
      directed_rows.push_back(row);
   endfunction

   // present one request in bursts and gaps, predict it once accepted
   task automatic issue_request(input logic op, input logic signed [KEY_W-1:0] key,
         input logic [REC_W-1:0] rec, input logic last, input logic typed,
         input result_type typed_result);
      result_type predicted;
      int         gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 7));
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, rec, key};
      req_tuser  <= op;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_index_op(op, key, rec, last);
      if (op == OP_INSERT && predicted.status == STATUS_INSERTED) stored_keys.push_back(key);
      awaited_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic issue_random_item();
      if ($urandom_range(0, 3) == 0)
         issue_request(OP_SEARCH, pick_search_key(), REC_W'($urandom), 1'($urandom),
                       1'b0, '0);
      else
         issue_request(OP_INSERT, pick_key(), REC_W'($urandom), 1'($urandom), 1'b0, '0);
   endtask

   // one chain run: mostly closed by a last mark, sometimes left open or cut short
   task automatic issue_chain_run(output int sent);
      int unsigned             len;
      int unsigned             shape;
      logic signed [KEY_W-1:0] key;
      logic signed [KEY_W-1:0] stride;
      logic                    last;
      len    = $urandom_range(1, 12);
      shape  = $urandom_range(0, 9);
      key    = pick_key();
      stride = KEY_W'($urandom_range(1, 5000));
      sent   = 0;
      for (int i = 0; i < int'(len); i++) begin
         last = (i == int'(len) - 1) && shape != 0;
         if (shape == 1 && $urandom_range(0, 3) == 0) last = 1'b1;
         issue_request(OP_INSERT, key, REC_W'($urandom), last, 1'b0, '0);
         sent++;
         if ($urandom_range(0, 5) == 0) begin
            issue_request(OP_SEARCH, pick_search_key(), REC_W'($urandom), 1'($urandom),
                          1'b0, '0);
            sent++;
         end
         key = (idx_order == ORDER_ASC) ? key + stride : key - stride;
      end
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // order register is only written with the block idle
   task automatic write_order(input logic [1:0] order);
      drain_requests();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= order;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      idx_order = order;
      csr_valid <= 1'b0;
      burst_left = 0;
   endtask

   // response check against the oldest awaited result
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing awaited, status %0d", rsp_tuser));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_tuser, want.status));
            if (rsp_tdata !== {4'b0, want.position})
               report_mismatch($sformatf("position %h, want %h", rsp_tdata, want.position));
         end
      end
   end

   initial begin
      stim_row_type row;
      int           issued;
      int           sent;
      logic [1:0]   order;

      // directed table
      add_item(OP_SEARCH, 0, 20'h12345, 1'b0, 1'b1, STATUS_NOT_FOUND, '0);
      add_cfg(ORDER_ASC);
      add_item(OP_INSERT, -1000, 20'h00001, 1'b0, 1'b1, STATUS_INSERTED, '0);
      add_item(OP_INSERT, -10, 20'h00002, 1'b0, 1'b1, STATUS_INSERTED, '0);
      add_item(OP_INSERT, 5, 20'h00003, 1'b0, 1'b1, STATUS_INSERTED, '0);
      add_item(OP_INSERT, 100, 20'h00004, 1'b1, 1'b1, STATUS_INSERTED, '0);
      add_item(OP_SEARCH, 5, 20'h00000, 1'b0, 1'b0, STATUS_INSERTED, '0);
      add_item(OP_SEARCH, 6, 20'h00000, 1'b0, 1'b0, STATUS_INSERTED, '0);
      // descending chain that no node points at
      add_cfg(ORDER_DESC);
      add_item(OP_INSERT, 3, 20'h00005, 1'b0, 1'b1, STATUS_INSERTED, '0);
      add_item(OP_INSERT, 2, 20'h00006, 1'b1, 1'b1, STATUS_INSERTED, '0);
      // spare mode behaves as a tree insert
      add_cfg(ORDER_SPARE);
      add_item(OP_INSERT, KEY_HIGH, 20'hFFFFF, 1'b0, 1'b1, STATUS_INSERTED, '0);
      add_cfg(ORDER_TREE);
      add_item(OP_INSERT, KEY_LOW, 20'h00000, 1'b1, 1'b1, STATUS_INSERTED, '0);
      add_item(OP_INSERT, 0, 20'h5A5A5, 1'b0, 1'b0, STATUS_INSERTED, '0);
      add_item(OP_INSERT, -1, 20'hA5A5A, 1'b1, 1'b0, STATUS_INSERTED, '0);
      add_item(OP_INSERT, 100, 20'h00007, 1'b0, 1'b1, STATUS_DUPLICATE, '0);
      add_item(OP_INSERT, 5, 20'h00008, 1'b1, 1'b1, STATUS_DUPLICATE, '0);
      add_item(OP_SEARCH, KEY_HIGH, 20'h00000, 1'b0, 1'b1, STATUS_FOUND, 20'hFFFFF);
      add_item(OP_SEARCH, KEY_LOW, 20'hFFFFF, 1'b1, 1'b1, STATUS_FOUND, 20'h00000);
      add_item(OP_SEARCH, 0, 20'hFFFFF, 1'b1, 1'b0, STATUS_INSERTED, '0);
      add_item(OP_SEARCH, -1, 20'h00000, 1'b0, 1'b0, STATUS_INSERTED, '0);
      add_item(OP_SEARCH, 2, 20'h00000, 1'b0, 1'b0, STATUS_INSERTED, '0);
      add_item(OP_SEARCH, 100, 20'h00000, 1'b1, 1'b0, STATUS_INSERTED, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) write_order(row.order);
         else issue_request(row.op, row.key, row.rec, row.last, row.typed, row.want);
      end

      // random phases under every input order
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            1, 5:    order = ORDER_ASC;
            2:       order = ORDER_SPARE;
            3, 7:    order = ORDER_DESC;
            default: order = ORDER_TREE;
         endcase
         write_order(order);
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            if (order == ORDER_ASC || order == ORDER_DESC) begin
               issue_chain_run(sent);
               issued += sent;
            end else begin
               issue_random_item();
               issued++;
            end
         end
      end

      // fill the table, then full-table inserts in tree and chain mode
      write_order(ORDER_TREE);
      while (idx_count < NODES)
         issue_request(OP_INSERT, pick_key(), REC_W'($urandom), 1'($urandom), 1'b0, '0);
      repeat (20) issue_random_item();
      write_order(ORDER_DESC);
      repeat (10) issue_random_item();

      drain_requests();
      repeat (NODES + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== binary_search_tree_index.f =====
design/bsti_pkg.sv
design/bsti_node_ram.sv
design/bsti_walker.sv
design/binary_search_tree_index.sv
dv/binary_search_tree_index_tb.sv
